FILE: rtl/fat16_cluster_chain_manager_assert.svh
// assertion macros used by the port checker file
`ifndef FAT16_CLUSTER_CHAIN_MANAGER_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_MANAGER_ASSERT_SVH

// clocked assertion with asynchronous reset disable
`define FCCM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define FCCM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`FCCM_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

FILE: rtl/fccm_pkg.sv
// types and constants of the fat16 cluster chain manager
package fccm_pkg;

	localparam int CMD_W = 2;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_ZERO = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD  = 2'd3;

	localparam logic [1:0] REG_CLUSTER_LIMIT = 2'd0;
	localparam logic [1:0] REG_MEDIA_TYPE    = 2'd1;
	localparam logic [1:0] REG_BYTES_PER_CL  = 2'd2;

	localparam logic [12:0] RST_CLUSTER_LIMIT = 13'd4096;
	localparam logic [7:0]  RST_MEDIA_TYPE    = 8'd248;
	localparam logic [16:0] RST_BYTES_PER_CL  = 17'd2048;

	localparam logic [15:0] MEDIA_HI = 16'hff00;
	localparam logic [15:0] LINK_EOC = 16'hffff;
	localparam logic [15:0] LINK_FREE = 16'h0000;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_RD_WAIT, S_FMT,
		S_ALC_EOC, S_ALC_RD, S_ALC_CHK, S_ALC_LNK,
		S_REL_RD, S_REL_WR, S_FRE_EOC, S_FRE_CHK, S_FRE_WR, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_CLR, OP_LOAD, OP_DISPATCH, OP_FMT, OP_EOC,
		OP_SCAN_RD, OP_SCAN_SKIP, OP_TAKE, OP_LINK, OP_REL_START,
		OP_WALK_RD, OP_UNLINK
	} op_t;

	typedef enum logic [1:0] {
		VAL_ZERO, VAL_RDATA, VAL_HEAD
	} val_sel_t;

	typedef struct packed {
		op_t             op;
		logic            res_en;
		val_sel_t        val_sel;
		logic [ST_W-1:0] st;
		logic            push;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic clr_last;
		logic fmt_last;
		logic rd_oob;
		logic rdata_zero;
		logic scan_end;
		logic count_zero;
		logic left_zero;
		logic cur_oob;
		logic cur_eoc;
		logic fre_bad;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/fccm_ram.sv
// generic single write, single read ram with registered read data
module fccm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/fccm_datapath.sv
// datapath: configuration, link table, scan and walk registers, result register
module fccm_datapath #(
	parameter int NUM_ENTRIES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_data,
	input  logic [1:0]   cmd,
	input  logic [15:0]  cluster,
	input  logic [31:0]  byte_length,
	input  fccm_pkg::ctl_t ctl,
	output fccm_pkg::sts_t sts,
	input  logic         out_ready,
	output logic         out_valid,
	output logic [15:0]  cluster_value,
	output logic [1:0]   status
);

	localparam int IW = $clog2(NUM_ENTRIES);
	localparam int LW = IW + 1;
	localparam int CW = (LW > 13) ? LW : 13;
	localparam logic [16:0] NUM17 = 17'(NUM_ENTRIES);

	logic [12:0] limit_q;
	logic [7:0]  media_q;
	logic [16:0] bpc_q;

	logic [1:0]    cmd_q;
	logic [15:0]   cl_q;
	logic [31:0]   left_q;
	logic [15:0]   eoc_q;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] scan_q;
	logic [IW-1:0] prev_q;
	logic [IW-1:0] head_q;
	logic [LW-1:0] count_q;
	logic [LW-1:0] steps_q;
	logic [15:0]   cur_q;
	logic [15:0]   res_val_q;
	logic [1:0]    res_st_q;
	logic          out_valid_q;
	logic [15:0]   out_val_q;
	logic [1:0]    out_st_q;

	logic [CW-1:0] lim_c;
	logic [16:0]   bpc_c;
	logic [31:0]   left_next;
	logic          we;
	logic [IW-1:0] waddr;
	logic [15:0]   wdata;
	logic [IW-1:0] raddr;
	logic [15:0]   rdata;

	fccm_ram #(.WIDTH(16), .DEPTH(NUM_ENTRIES)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fccm_pkg::RST_CLUSTER_LIMIT;
			media_q <= fccm_pkg::RST_MEDIA_TYPE;
			bpc_q   <= fccm_pkg::RST_BYTES_PER_CL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fccm_pkg::REG_CLUSTER_LIMIT: limit_q <= cfg_data[12:0];
				fccm_pkg::REG_MEDIA_TYPE:    media_q <= cfg_data[7:0];
				fccm_pkg::REG_BYTES_PER_CL:  bpc_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		lim_c = (CW'(limit_q) > CW'(NUM_ENTRIES)) ? CW'(NUM_ENTRIES) : CW'(limit_q);
		bpc_c = (bpc_q == '0) ? 17'd1 : bpc_q;
		left_next = (left_q > 32'(bpc_c)) ? left_q - 32'(bpc_c) : '0;
	end

	// table write and read port selection
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = fccm_pkg::LINK_FREE;
		raddr = '0;
		case (ctl.op)
			fccm_pkg::OP_CLR: begin
				we    = 1'b1;
				waddr = cnt_q[IW-1:0];
			end
			fccm_pkg::OP_FMT: begin
				we    = 1'b1;
				waddr = cnt_q[IW-1:0];
				if (cnt_q == LW'(0)) begin
					wdata = fccm_pkg::MEDIA_HI | {8'd0, media_q};
				end else if (cnt_q == LW'(1)) begin
					wdata = fccm_pkg::LINK_EOC;
				end
			end
			fccm_pkg::OP_TAKE: begin
				we    = 1'b1;
				waddr = scan_q[IW-1:0];
				wdata = eoc_q;
			end
			fccm_pkg::OP_LINK: begin
				// first cluster of a chain has no predecessor
				we    = (count_q > LW'(1));
				waddr = prev_q;
				wdata = 16'(scan_q);
			end
			fccm_pkg::OP_UNLINK: begin
				we    = 1'b1;
				waddr = cur_q[IW-1:0];
			end
			fccm_pkg::OP_DISPATCH: begin
				raddr = (cmd_q == fccm_pkg::CMD_READ) ? cl_q[IW-1:0] : IW'(1);
			end
			fccm_pkg::OP_SCAN_RD: raddr = scan_q[IW-1:0];
			fccm_pkg::OP_WALK_RD: raddr = cur_q[IW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.op == fccm_pkg::OP_CLR || ctl.op == fccm_pkg::OP_FMT) begin
				cnt_q <= cnt_q + LW'(1);
			end else if (ctl.op == fccm_pkg::OP_DISPATCH) begin
				cnt_q <= '0;
			end
			if (ctl.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			fccm_pkg::OP_LOAD: begin
				cmd_q  <= cmd;
				cl_q   <= cluster;
				left_q <= byte_length;
			end
			fccm_pkg::OP_DISPATCH: begin
				scan_q  <= LW'(2);
				count_q <= '0;
				steps_q <= '0;
				cur_q   <= cl_q;
			end
			fccm_pkg::OP_EOC:       eoc_q  <= rdata;
			fccm_pkg::OP_SCAN_SKIP: scan_q <= scan_q + LW'(1);
			fccm_pkg::OP_TAKE: begin
				if (count_q == '0) begin
					head_q <= scan_q[IW-1:0];
				end
				count_q <= count_q + LW'(1);
				left_q  <= left_next;
			end
			fccm_pkg::OP_LINK: begin
				prev_q <= scan_q[IW-1:0];
				scan_q <= scan_q + LW'(1);
			end
			fccm_pkg::OP_REL_START: cur_q <= 16'(head_q);
			fccm_pkg::OP_UNLINK: begin
				cur_q   <= rdata;
				count_q <= count_q - LW'(1);
				steps_q <= steps_q + LW'(1);
			end
			default: ;
		endcase
		if (ctl.res_en) begin
			case (ctl.val_sel)
				fccm_pkg::VAL_RDATA: res_val_q <= rdata;
				fccm_pkg::VAL_HEAD:  res_val_q <= 16'(head_q);
				default:             res_val_q <= '0;
			endcase
			res_st_q <= ctl.st;
		end
		if (ctl.push) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
		end
	end

	always_comb begin
		sts.cmd        = cmd_q;
		sts.clr_last   = (cnt_q == LW'(NUM_ENTRIES - 1));
		sts.fmt_last   = (cnt_q != '0) && (CW'(cnt_q) + CW'(1) >= lim_c);
		sts.rd_oob     = ({1'b0, cl_q} >= NUM17);
		sts.rdata_zero = (rdata == '0);
		sts.scan_end   = (CW'(scan_q) >= lim_c);
		sts.count_zero = (count_q == '0);
		sts.left_zero  = (left_q == '0);
		sts.cur_oob    = ({1'b0, cur_q} >= NUM17);
		sts.cur_eoc    = (cur_q == eoc_q);
		sts.fre_bad    = (cur_q < 16'd2) || ({1'b0, cur_q} >= 17'(lim_c))
			|| (steps_q >= LW'(NUM_ENTRIES));
		sts.out_busy   = out_valid_q && !out_ready;
	end

	assign out_valid     = out_valid_q;
	assign cluster_value = out_val_q;
	assign status        = out_st_q;

endmodule

FILE: rtl/fccm_ctrl.sv
// command sequencer for clear, format, allocate, release, free and read
module fccm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fccm_pkg::sts_t sts,
	output fccm_pkg::ctl_t ctl
);

	fccm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fccm_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		ctl.op      = fccm_pkg::OP_NOP;
		ctl.res_en  = 1'b0;
		ctl.val_sel = fccm_pkg::VAL_ZERO;
		ctl.st      = fccm_pkg::ST_OK;
		ctl.push    = 1'b0;
		unique case (state_q)
			fccm_pkg::S_CLR: begin
				ctl.op = fccm_pkg::OP_CLR;
				if (sts.clr_last) state_d = fccm_pkg::S_IDLE;
			end
			fccm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op  = fccm_pkg::OP_LOAD;
					state_d = fccm_pkg::S_DISP;
				end
			end
			fccm_pkg::S_DISP: begin
				ctl.op = fccm_pkg::OP_DISPATCH;
				unique case (sts.cmd)
					fccm_pkg::CMD_FORMAT: state_d = fccm_pkg::S_FMT;
					fccm_pkg::CMD_ALLOC: begin
						if (sts.left_zero) begin
							ctl.res_en = 1'b1;
							ctl.st     = fccm_pkg::ST_ZERO;
							state_d    = fccm_pkg::S_DONE;
						end else begin
							state_d = fccm_pkg::S_ALC_EOC;
						end
					end
					fccm_pkg::CMD_FREE: state_d = fccm_pkg::S_FRE_EOC;
					default: begin
						if (sts.rd_oob) begin
							ctl.res_en = 1'b1;
							ctl.st     = fccm_pkg::ST_BAD;
							state_d    = fccm_pkg::S_DONE;
						end else begin
							state_d = fccm_pkg::S_RD_WAIT;
						end
					end
				endcase
			end
			fccm_pkg::S_RD_WAIT: begin
				ctl.res_en  = 1'b1;
				ctl.val_sel = fccm_pkg::VAL_RDATA;
				state_d     = fccm_pkg::S_DONE;
			end
			fccm_pkg::S_FMT: begin
				ctl.op = fccm_pkg::OP_FMT;
				if (sts.fmt_last) begin
					ctl.res_en = 1'b1;
					state_d    = fccm_pkg::S_DONE;
				end
			end
			fccm_pkg::S_ALC_EOC: begin
				ctl.op = fccm_pkg::OP_EOC;
				// no end-of-chain mark means nothing can be marked used
				if (sts.rdata_zero) begin
					ctl.res_en = 1'b1;
					ctl.st     = fccm_pkg::ST_FULL;
					state_d    = fccm_pkg::S_DONE;
				end else begin
					state_d = fccm_pkg::S_ALC_RD;
				end
			end
			fccm_pkg::S_ALC_RD: begin
				if (sts.scan_end) begin
					if (sts.count_zero) begin
						ctl.res_en = 1'b1;
						ctl.st     = fccm_pkg::ST_FULL;
						state_d    = fccm_pkg::S_DONE;
					end else begin
						ctl.op  = fccm_pkg::OP_REL_START;
						state_d = fccm_pkg::S_REL_RD;
					end
				end else begin
					ctl.op  = fccm_pkg::OP_SCAN_RD;
					state_d = fccm_pkg::S_ALC_CHK;
				end
			end
			fccm_pkg::S_ALC_CHK: begin
				if (sts.rdata_zero) begin
					ctl.op  = fccm_pkg::OP_TAKE;
					state_d = fccm_pkg::S_ALC_LNK;
				end else begin
					ctl.op  = fccm_pkg::OP_SCAN_SKIP;
					state_d = fccm_pkg::S_ALC_RD;
				end
			end
			fccm_pkg::S_ALC_LNK: begin
				ctl.op = fccm_pkg::OP_LINK;
				if (sts.left_zero) begin
					ctl.res_en  = 1'b1;
					ctl.val_sel = fccm_pkg::VAL_HEAD;
					state_d     = fccm_pkg::S_DONE;
				end else begin
					state_d = fccm_pkg::S_ALC_RD;
				end
			end
			fccm_pkg::S_REL_RD: begin
				if (sts.count_zero || sts.cur_oob) begin
					ctl.res_en = 1'b1;
					ctl.st     = fccm_pkg::ST_FULL;
					state_d    = fccm_pkg::S_DONE;
				end else begin
					ctl.op  = fccm_pkg::OP_WALK_RD;
					state_d = fccm_pkg::S_REL_WR;
				end
			end
			fccm_pkg::S_REL_WR: begin
				ctl.op  = fccm_pkg::OP_UNLINK;
				state_d = fccm_pkg::S_REL_RD;
			end
			fccm_pkg::S_FRE_EOC: begin
				ctl.op  = fccm_pkg::OP_EOC;
				state_d = fccm_pkg::S_FRE_CHK;
			end
			fccm_pkg::S_FRE_CHK: begin
				if (sts.cur_eoc) begin
					ctl.res_en = 1'b1;
					state_d    = fccm_pkg::S_DONE;
				end else if (sts.fre_bad) begin
					ctl.res_en = 1'b1;
					ctl.st     = fccm_pkg::ST_BAD;
					state_d    = fccm_pkg::S_DONE;
				end else begin
					ctl.op  = fccm_pkg::OP_WALK_RD;
					state_d = fccm_pkg::S_FRE_WR;
				end
			end
			fccm_pkg::S_FRE_WR: begin
				ctl.op  = fccm_pkg::OP_UNLINK;
				state_d = fccm_pkg::S_FRE_CHK;
			end
			fccm_pkg::S_DONE: begin
				if (!sts.out_busy) begin
					ctl.push = 1'b1;
					state_d  = fccm_pkg::S_IDLE;
				end
			end
			default: state_d = fccm_pkg::S_IDLE;
		endcase
	end

endmodule

FILE: rtl/fat16_cluster_chain_manager.sv
// top level: fat16 allocation table with stream command and result channels
//
// commands enter on s_axis (one beat per command), one result beat leaves on
// m_axis for every command. configuration is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while no command is in flight, as the
// block itself does not enforce this. after arst_n is released the table is
// swept to zero, one entry per cycle; s_axis_tready stays low during the sweep.
// one command is worked at a time over a single-port-read table ram:
//   read: the entry at the cluster is read and returned
//   format: media word, end-of-chain mark, then zero up to the cluster limit
//   allocate: free entries are scanned from 2, marked and linked into a chain,
//     released again when space runs out; free: the chain is walked and cleared
// the result sits in an output register; the next command is taken while it
// waits, and the block holds its own finished result until m_axis_tready frees
// that register.
module fat16_cluster_chain_manager #(
	parameter int NUM_ENTRIES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // cmd[1:0], cluster[17:2], byte_length[49:18]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata    // cluster_value[15:0], status[17:16]
);

	fccm_pkg::ctl_t ctl;
	fccm_pkg::sts_t sts;
	logic [15:0] cluster_value;
	logic [1:0]  status;

	fccm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	fccm_datapath #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (s_axis_tdata[1:0]),
		.cluster       (s_axis_tdata[17:2]),
		.byte_length   (s_axis_tdata[49:18]),
		.ctl           (ctl),
		.sts           (sts),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.cluster_value (cluster_value),
		.status        (status)
	);

	assign m_axis_tdata = {6'd0, status, cluster_value};

endmodule

FILE: rtl/fccm_checker.sv
// port-level checks of the fat16 cluster chain manager
`include "fat16_cluster_chain_manager_assert.svh"

module fccm_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [16:0] cfg_data,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [55:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// a stalled result beat keeps its value
	`FCCM_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	// one command at a time
	`FCCM_ASSERT(a_one_cmd, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second command taken while busy")

	// failures report a zero cluster value
	`FCCM_ASSERT(a_fail_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[17:16] != 2'd0 |-> m_axis_tdata[15:0] == 16'd0, "failure with nonzero cluster value")

	`FCCM_ASSERT_NEVER(a_pad_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[23:18] != 6'd0, "result padding bits set")

endmodule

bind fat16_cluster_chain_manager fccm_port_checks u_fccm_port_checks (.*);
